[rtl/srr_pkg.sv]
package srr_pkg;

   localparam int MAX_ROWS = 32;
   localparam int SLOTS    = 32;
   localparam int ROW_CAP  = (MAX_ROWS < SLOTS) ? MAX_ROWS : SLOTS;

   typedef struct packed {
      logic              row_valid;
      logic [47:0]       row_mac;
      logic signed [7:0] row_rssi;
      logic              last_row;
   } req_type;

   typedef struct packed {
      logic [4:0]        source_index;
      logic [47:0]       out_mac;
      logic signed [7:0] out_rssi;
      logic              is_last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic run_init;
      logic sel_j;
      logic match_hit;
      logic match_next_j;
      logic match_next_i;
      logic pick_skip;
      logic pick_take;
      logic scan_next;
      logic scan_insert;
      logic emit_init;
      logic emit_row;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic i_done;
      logic hit;
      logic j_last;
      logic j_done;
      logic j_claimed;
      logic k_place;
      logic emit_last;
      logic none;
   } status_type;

endpackage

[rtl/srr_ctrl.sv]
module srr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                row_valid,
   input  logic                last_row,
   input  srr_pkg::status_type status,
   output srr_pkg::cmd_type    cmd,
   output logic                busy
);
   import srr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MATCH = 5'b00010,
      ST_PICK  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = row_valid;
               if (last_row) begin
                  cmd.run_init = 1'b1;
                  state_in     = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            cmd.sel_j = 1'b1;
            if (status.i_done) begin
               state_in = ST_PICK;
            end else if (status.hit) begin
               cmd.match_hit = 1'b1;
            end else if (status.j_last) begin
               cmd.match_next_i = 1'b1;
            end else begin
               cmd.match_next_j = 1'b1;
            end
         end
         ST_PICK: begin
            cmd.sel_j = 1'b1;
            if (status.j_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end else if (status.j_claimed) begin
               cmd.pick_skip = 1'b1;
            end else begin
               cmd.pick_take = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.k_place) begin
               cmd.scan_insert = 1'b1;
               state_in        = ST_PICK;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.none) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.emit_row = 1'b1;
               if (status.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/srr_dp.sv]
module srr_dp (
   input  logic                clock,
   input  logic                reset,
   input  srr_pkg::req_type    req_data,
   input  srr_pkg::cmd_type    cmd,
   output srr_pkg::status_type status,
   output logic                rsp_strobe,
   output srr_pkg::rsp_type    rsp_data
);
   import srr_pkg::*;

   logic [47:0]       kept_mac_ff   [SLOTS];
   logic [47:0]       loaded_mac_ff [SLOTS];
   logic signed [7:0] loaded_rssi_ff[SLOTS];
   logic [4:0]        order_ff      [SLOTS];
   logic [SLOTS-1:0]  claimed_ff;
   logic [5:0]        kept_count_ff;
   logic [5:0]        loaded_count_ff;
   logic [5:0]        placed_ff;
   logic [5:0]        i_ff;
   logic [5:0]        j_ff;
   logic [5:0]        k_ff;
   logic signed [7:0] cand_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;

   logic [4:0]        src;
   logic [4:0]        rd_addr;
   logic [47:0]       mac_rd;
   logic signed [7:0] rssi_rd;

   // order entry at the scan / emit position
   assign src     = order_ff[k_ff[4:0]];
   assign rd_addr = cmd.sel_j ? j_ff[4:0] : src;
   assign mac_rd  = loaded_mac_ff[rd_addr];
   assign rssi_rd = loaded_rssi_ff[rd_addr];

   assign status.i_done    = (i_ff >= kept_count_ff) || (loaded_count_ff == 6'd0);
   assign status.hit       = !claimed_ff[j_ff[4:0]] && (mac_rd == kept_mac_ff[i_ff[4:0]]);
   assign status.j_last    = ((j_ff + 6'd1) >= loaded_count_ff);
   assign status.j_done    = (j_ff >= loaded_count_ff);
   assign status.j_claimed = claimed_ff[j_ff[4:0]];
   assign status.k_place   = (k_ff >= placed_ff) || (cand_ff > rssi_rd);
   assign status.emit_last = ((k_ff + 6'd1) >= placed_ff);
   assign status.none      = (placed_ff == 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff   <= '0;
         loaded_count_ff <= '0;
         claimed_ff      <= '0;
         placed_ff       <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         k_ff            <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_row;
         if (cmd.load && (loaded_count_ff < 6'(ROW_CAP))) begin
            loaded_mac_ff[loaded_count_ff[4:0]]  <= req_data.row_mac;
            loaded_rssi_ff[loaded_count_ff[4:0]] <= req_data.row_rssi;
            loaded_count_ff                      <= loaded_count_ff + 6'd1;
         end
         if (cmd.run_init) begin
            i_ff      <= '0;
            j_ff      <= '0;
            placed_ff <= '0;
            claimed_ff <= '0;
         end
         if (cmd.match_hit) begin
            order_ff[placed_ff[4:0]] <= j_ff[4:0];
            claimed_ff[j_ff[4:0]]    <= 1'b1;
            placed_ff                <= placed_ff + 6'd1;
            i_ff                     <= i_ff + 6'd1;
            j_ff                     <= '0;
         end
         if (cmd.match_next_i) begin
            i_ff <= i_ff + 6'd1;
            j_ff <= '0;
         end
         if (cmd.match_next_j || cmd.pick_skip) begin
            j_ff <= j_ff + 6'd1;
         end
         if (cmd.pick_take) begin
            cand_ff <= rssi_rd;
            k_ff    <= '0;
         end
         if (cmd.scan_next) begin
            k_ff <= k_ff + 6'd1;
         end
         if (cmd.scan_insert) begin
            // open a gap at k and drop the candidate in
            for (int e = 0; e < SLOTS; e++) begin
               if (6'(e) == k_ff) begin
                  order_ff[e] <= j_ff[4:0];
               end else if ((e > 0) && (6'(e) > k_ff) && (6'(e) <= placed_ff)) begin
                  order_ff[e] <= order_ff[(e > 0) ? e - 1 : 0];
               end
            end
            claimed_ff[j_ff[4:0]] <= 1'b1;
            placed_ff             <= placed_ff + 6'd1;
            j_ff                  <= j_ff + 6'd1;
         end
         if (cmd.emit_init) begin
            k_ff <= '0;
         end
         if (cmd.emit_row) begin
            kept_mac_ff[k_ff[4:0]] <= mac_rd;
            rsp_ff.source_index    <= src;
            rsp_ff.out_mac         <= mac_rd;
            rsp_ff.out_rssi        <= rssi_rd;
            rsp_ff.is_last         <= status.emit_last;
            k_ff                   <= k_ff + 6'd1;
         end
         if (cmd.finish) begin
            kept_count_ff   <= placed_ff;
            loaded_count_ff <= '0;
            claimed_ff      <= '0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/sticky_order_reranker.sv]
// sticky order reranker
// input: an item is taken when start is high and busy is low; each item
// carries at most one row (mac and signed rssi) and may carry the last mark.
// rows beyond 32 in a snapshot are dropped, the last mark still counts.
// a plain row is taken and busy stays low.
// on the last mark busy rises and a run starts: the previous emitted order
// is walked, each kept mac compared with one loaded row a cycle, then each
// remaining row is inserted by rssi, one placed entry compared a cycle.
// the rows then leave one a cycle on rsp_data with rsp_strobe high for
// exactly one cycle each, is_last on the final one; the receiver cannot
// stall, every strobe is a transfer. busy falls with the final row.
// an empty snapshot end emits nothing and clears the kept order.
// reset clears the kept order and any half loaded snapshot.
module sticky_order_reranker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output srr_pkg::rsp_type rsp_data
);
   import srr_pkg::*;

   cmd_type    cmd;
   status_type status;

   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .row_valid (req_data.row_valid),
      .last_row  (req_data.last_row),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   srr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
